>>> design/spi_pkg.sv
// ----------------------------------------------------------------------------
// spi_pkg: shared types, widths and helpers for the segment intersection unit
// Transaction structs for both channels, pipeline item types and the
// per-stage restoring-division step used by the divider pipeline.
// ----------------------------------------------------------------------------
package spi_pkg;

  // Coordinate width. The fraction position does not affect any step: all
  // values share one scale and rounding is to the least significant bit.
  localparam int unsigned CW = 16;
  localparam int unsigned DW = CW + 1;        // coordinate differences
  localparam int unsigned PW = 2 * DW;        // one cross-product term
  localparam int unsigned NW = PW + 1;        // den, tn, un
  localparam int unsigned QW = CW;            // quotient bits (|offset| < 2^CW)
  localparam int unsigned MW = CW + NW;       // |r| * tn dividend

  typedef struct packed {
    logic signed [CW-1:0] a_start_x;
    logic signed [CW-1:0] a_start_y;
    logic signed [CW-1:0] a_end_x;
    logic signed [CW-1:0] a_end_y;
    logic signed [CW-1:0] b_start_x;
    logic signed [CW-1:0] b_start_y;
    logic signed [CW-1:0] b_end_x;
    logic signed [CW-1:0] b_end_y;
  } in_item_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] cross_x;
    logic signed [CW-1:0] cross_y;
  } out_item_t;

  // One coordinate lane of the divider pipeline.
  typedef struct packed {
    logic [MW-1:0] rem;
    logic [QW-1:0] quo;
    logic          neg;
    logic [CW-1:0] base;
  } div_lane_t;

  typedef struct packed {
    logic          hit;
    logic [NW-1:0] den;
    div_lane_t     lx;
    div_lane_t     ly;
  } div_item_t;

  // One restoring-division step: try to take den shifted by sh out of the
  // remainder and shift the resulting quotient bit in at the bottom.
  function automatic div_lane_t div_step(div_lane_t l, logic [NW-1:0] den,
                                         int unsigned sh);
    logic [MW-1:0] dsh;
    logic          ge;
    div_lane_t     o;
    dsh = MW'(den) << sh;
    ge  = (l.rem >= dsh);
    o   = l;
    if (ge) begin
      o.rem = l.rem - dsh;
    end
    o.quo = {l.quo[QW-2:0], ge};
    return o;
  endfunction

  // Apply the sign of the offset with floor rounding and add the start point.
  function automatic logic [CW-1:0] lane_fix(div_lane_t l, logic hit);
    logic          rem_nz;
    logic [CW:0]   q_ext;
    logic [CW:0]   off;
    logic [CW-1:0] sum;
    q_ext  = {1'b0, l.quo};
    rem_nz = |l.rem;
    if (!l.neg) begin
      off = q_ext;
    end else if (rem_nz) begin
      off = ~q_ext;
    end else begin
      off = -q_ext;
    end
    sum = l.base + off[CW-1:0];
    return hit ? sum : '0;
  endfunction

endpackage

>>> design/segment_pair_intersection_unit.sv
// ----------------------------------------------------------------------------
// segment_pair_intersection_unit: strict 2D segment crossing test
// Reports whether two segments cross strictly inside both and, on a hit,
// the floor-rounded crossing point.
// ----------------------------------------------------------------------------
// The unit takes one segment pair per clock while in_stall is low and returns
// one result per pair, in order: six stages form the cross products, normalize
// the sign of the denominator and test 0 < t < 1 and 0 < u < 1, sixteen stages
// of a restoring divider produce one quotient bit each for both coordinates,
// and the output register presents the result. The divider depth, one stage
// per result bit, sets the latency. A skid stage behind the output register
// lets one more result land while the consumer stalls; after that, in_stall
// rises and the whole pipeline holds. Parallel segments, zero-length segments
// and touches at an end report no hit with a zero crossing point.
module segment_pair_intersection_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  spi_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output spi_pkg::out_item_t out_item
);
  import spi_pkg::*;

  logic      en;
  logic      front_vld;
  div_item_t front_data;
  logic      div_vld;
  out_item_t div_data;

  assign in_stall = !en;

  spi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .in_data  (in_item),
    .out_vld  (front_vld),
    .out_data (front_data)
  );

  spi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (front_vld),
    .in_data  (front_data),
    .out_vld  (div_vld),
    .out_data (div_data)
  );

  spi_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (div_vld),
    .push_data (div_data),
    .en        (en),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

>>> design/spi_front.sv
// ----------------------------------------------------------------------------
// spi_front: cross products, sign normalization and strict-crossing test
// Six register stages from the input coordinates to the dividend and divisor
// handed to the divider pipeline.
// ----------------------------------------------------------------------------
module spi_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  spi_pkg::in_item_t in_data,
  output logic              out_vld,
  output spi_pkg::div_item_t out_data
);
  import spi_pkg::*;

  logic [6:1] vld_r;

  // Stage 1: differences.
  logic signed [DW-1:0] rx1_r, ry1_r, sx1_r, sy1_r, qx1_r, qy1_r;
  logic signed [CW-1:0] ax1_r, ay1_r;
  // Stage 2: products.
  logic signed [PW-1:0] m_rs_r, m_rysx_r, m_qs_r, m_qysx_r, m_qr_r, m_qyrx_r;
  logic signed [DW-1:0] rx2_r, ry2_r;
  logic signed [CW-1:0] ax2_r, ay2_r;
  // Stage 3: den, tn, un.
  logic signed [NW-1:0] den3_r, tn3_r, un3_r;
  logic signed [DW-1:0] rx3_r, ry3_r;
  logic signed [CW-1:0] ax3_r, ay3_r;
  // Stage 4: den made positive.
  logic signed [NW-1:0] den4_r, tn4_r, un4_r;
  logic signed [DW-1:0] rx4_r, ry4_r;
  logic signed [CW-1:0] ax4_r, ay4_r;
  // Stage 5: hit test and magnitudes.
  logic                 hit5_r;
  logic [NW-1:0]        den5_r, tn5_r;
  logic [CW-1:0]        mrx5_r, mry5_r;
  logic                 nx5_r, ny5_r;
  logic [CW-1:0]        ax5_r, ay5_r;
  // Stage 6: dividends.
  div_item_t            item6_r;

  logic signed [DW-1:0] mrx_full, mry_full;
  logic                 hit_nxt;
  div_item_t            item6_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:1], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx1_r <= DW'(in_data.a_end_x) - DW'(in_data.a_start_x);
      ry1_r <= DW'(in_data.a_end_y) - DW'(in_data.a_start_y);
      sx1_r <= DW'(in_data.b_end_x) - DW'(in_data.b_start_x);
      sy1_r <= DW'(in_data.b_end_y) - DW'(in_data.b_start_y);
      qx1_r <= DW'(in_data.b_start_x) - DW'(in_data.a_start_x);
      qy1_r <= DW'(in_data.b_start_y) - DW'(in_data.a_start_y);
      ax1_r <= in_data.a_start_x;
      ay1_r <= in_data.a_start_y;

      m_rs_r   <= rx1_r * sy1_r;
      m_rysx_r <= ry1_r * sx1_r;
      m_qs_r   <= qx1_r * sy1_r;
      m_qysx_r <= qy1_r * sx1_r;
      m_qr_r   <= qx1_r * ry1_r;
      m_qyrx_r <= qy1_r * rx1_r;
      rx2_r <= rx1_r;
      ry2_r <= ry1_r;
      ax2_r <= ax1_r;
      ay2_r <= ay1_r;

      den3_r <= NW'(m_rs_r) - NW'(m_rysx_r);
      tn3_r  <= NW'(m_qs_r) - NW'(m_qysx_r);
      un3_r  <= NW'(m_qr_r) - NW'(m_qyrx_r);
      rx3_r <= rx2_r;
      ry3_r <= ry2_r;
      ax3_r <= ax2_r;
      ay3_r <= ay2_r;

      den4_r <= den3_r[NW-1] ? -den3_r : den3_r;
      tn4_r  <= den3_r[NW-1] ? -tn3_r  : tn3_r;
      un4_r  <= den3_r[NW-1] ? -un3_r  : un3_r;
      rx4_r <= rx3_r;
      ry4_r <= ry3_r;
      ax4_r <= ax3_r;
      ay4_r <= ay3_r;

      hit5_r <= hit_nxt;
      den5_r <= den4_r;
      tn5_r  <= hit_nxt ? tn4_r : '0;
      mrx5_r <= mrx_full[CW-1:0];
      mry5_r <= mry_full[CW-1:0];
      nx5_r  <= rx4_r[DW-1];
      ny5_r  <= ry4_r[DW-1];
      ax5_r  <= ax4_r;
      ay5_r  <= ay4_r;

      item6_r <= item6_nxt;
    end
  end

  // Strict crossing: 0 < tn < den and 0 < un < den, with den made positive.
  always_comb begin
    hit_nxt = (den4_r != 0) && (tn4_r > 0) && (un4_r > 0) &&
              (tn4_r < den4_r) && (un4_r < den4_r);
    mrx_full = rx4_r[DW-1] ? -rx4_r : rx4_r;
    mry_full = ry4_r[DW-1] ? -ry4_r : ry4_r;
  end

  always_comb begin
    item6_nxt.hit     = hit5_r;
    item6_nxt.den     = den5_r;
    item6_nxt.lx.rem  = mrx5_r * tn5_r;
    item6_nxt.lx.quo  = '0;
    item6_nxt.lx.neg  = nx5_r;
    item6_nxt.lx.base = ax5_r;
    item6_nxt.ly.rem  = mry5_r * tn5_r;
    item6_nxt.ly.quo  = '0;
    item6_nxt.ly.neg  = ny5_r;
    item6_nxt.ly.base = ay5_r;
  end

  assign out_vld  = vld_r[6];
  assign out_data = item6_r;

endmodule

>>> design/spi_div.sv
// ----------------------------------------------------------------------------
// spi_div: pipelined restoring divider for both crossing coordinates
// One quotient bit per register stage, then floor correction of the sign
// and the add of the segment start point.
// ----------------------------------------------------------------------------
module spi_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  spi_pkg::div_item_t in_data,
  output logic               out_vld,
  output spi_pkg::out_item_t out_data
);
  import spi_pkg::*;

  logic      vld_r [1:QW];
  div_item_t stg_r [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int unsigned SH = QW - 1 - k;
    div_item_t src;
    logic      src_vld;
    div_item_t stg_nxt;

    if (k == 0) begin : g_first
      assign src     = in_data;
      assign src_vld = in_vld;
    end else begin : g_rest
      assign src     = stg_r[k];
      assign src_vld = vld_r[k];
    end

    always_comb begin
      stg_nxt     = src;
      stg_nxt.lx  = div_step(src.lx, src.den, SH);
      stg_nxt.ly  = div_step(src.ly, src.den, SH);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[k+1] <= stg_nxt;
      end
    end
  end

  always_comb begin
    out_data.hit     = stg_r[QW].hit;
    out_data.cross_x = lane_fix(stg_r[QW].lx, stg_r[QW].hit);
    out_data.cross_y = lane_fix(stg_r[QW].ly, stg_r[QW].hit);
  end

  assign out_vld = vld_r[QW];

endmodule

>>> design/spi_obuf.sv
// ----------------------------------------------------------------------------
// spi_obuf: output register with skid stage
// Holds a result while the consumer stalls and freezes the pipeline from a
// registered flag, so no stall path runs back to the input.
// ----------------------------------------------------------------------------
module spi_obuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_vld,
  input  spi_pkg::out_item_t push_data,
  output logic               en,
  output logic               out_valid,
  input  logic               out_stall,
  output spi_pkg::out_item_t out_item
);
  import spi_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  out_item_t skid_data_r, skid_data_nxt;
  logic      pop;
  logic      push;

  assign en   = !skid_valid_r;
  assign pop  = out_valid_r && !out_stall;
  assign push = en && push_vld;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_nxt  = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_data_r;

endmodule

>>> design/spi_checker.sv
// ----------------------------------------------------------------------------
// spi_checker: port-level checks for the segment intersection unit
// Watches the handshakes and result fields seen at the top-level ports.
// ----------------------------------------------------------------------------
module spi_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input spi_pkg::out_item_t out_item
);
  import spi_pkg::*;

  // A pending result is not withdrawn while the consumer stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // A miss always carries a zero crossing point.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.hit |-> out_item.cross_x == '0 && out_item.cross_y == '0)
    else $error("miss with nonzero crossing point");

  // Input back-pressure only starts after the output was stalled with data.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("in_stall rose without output back-pressure");

  // While the input is stalled, a result is waiting at the output.
  a_stall_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall high with no pending result");

endmodule

bind segment_pair_intersection_unit spi_checker u_spi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the segment pair intersection unit
// Streams segment pairs through the unit under bursty input and a stalling
// consumer, predicts each hit flag and floor-rounded crossing point with
// exact integer arithmetic, and compares every result in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spi_pkg::*;

  localparam int unsigned RANDOM_PAIRS   = 1950;
  localparam int unsigned HOLD_AFTER     = 600;     // accepted pairs before the long stall
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_AT       = 1200;    // sender waits for an empty pipe here
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned TIMEOUT_CYCLES = 400000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  in_item_t  pair_q[$];
  out_item_t crossing_q[$];

  int unsigned sent_cnt     = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned burst_left   = 0;
  int unsigned gap_left     = 0;
  int unsigned hold_left    = 0;
  int unsigned mode_left    = 0;
  bit          hold_done    = 1'b0;
  logic        long_hold    = 1'b0;
  stall_mode_t stall_mode   = STALL_NONE;

  segment_pair_intersection_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    forever #6ns clk = ~clk;
  end

  // Floor division for a positive divisor.
  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  function automatic out_item_t predict_crossing(in_item_t p);
    longint    ax, ay, rx, ry, bx, by, sx, sy, qx, qy, den, tn, un;
    out_item_t r;
    ax  = p.a_start_x;
    ay  = p.a_start_y;
    bx  = p.b_start_x;
    by  = p.b_start_y;
    rx  = longint'(p.a_end_x) - ax;
    ry  = longint'(p.a_end_y) - ay;
    sx  = longint'(p.b_end_x) - bx;
    sy  = longint'(p.b_end_y) - by;
    qx  = bx - ax;
    qy  = by - ay;
    den = rx * sy - ry * sx;
    tn  = qx * sy - qy * sx;
    un  = qx * ry - qy * rx;
    r   = '0;
    if (den == 0) begin
      return r;
    end
    if (den < 0) begin
      den = -den;
      tn  = -tn;
      un  = -un;
    end
    // Only a crossing strictly inside both segments counts.
    if (tn <= 0 || tn >= den || un <= 0 || un >= den) begin
      return r;
    end
    r.hit     = 1'b1;
    r.cross_x = CW'(ax + floor_div(rx * tn, den));
    r.cross_y = CW'(ay + floor_div(ry * tn, den));
    return r;
  endfunction

  task automatic add_pair(int ax, int ay, int aex, int aey,
                          int bx, int by, int bex, int bey);
    in_item_t p;
    p.a_start_x = CW'(ax);
    p.a_start_y = CW'(ay);
    p.a_end_x   = CW'(aex);
    p.a_end_y   = CW'(aey);
    p.b_start_x = CW'(bx);
    p.b_start_y = CW'(by);
    p.b_end_x   = CW'(bex);
    p.b_end_y   = CW'(bey);
    pair_q.push_back(p);
  endtask

  function automatic int rnd(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  task automatic add_random_pair();
    int ax, ay, aex, aey, bx, by, bex, bey;
    int cx, cy, v1x, v1y, v2x, v2y, hx, hy, m1, m2;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind <= 3) begin
      // Two segments built through a common point, so most of them cross.
      cx  = rnd(-12000, 12000);
      cy  = rnd(-12000, 12000);
      v1x = rnd(-10000, 10000);
      v1y = rnd(-10000, 10000);
      v2x = rnd(-10000, 10000);
      v2y = rnd(-10000, 10000);
      case ($urandom_range(0, 7))
        0: begin v1x = 0; v2y = 0; end
        1: begin v1y = 0; v2x = 0; end
        default: ;
      endcase
      m1  = rnd(1, 4);
      m2  = rnd(1, 4);
      ax  = cx - v1x;
      ay  = cy - v1y;
      aex = cx + (v1x * m1) / 4;
      aey = cy + (v1y * m1) / 4;
      bx  = cx - v2x;
      by  = cy - v2y;
      bex = cx + (v2x * m2) / 4;
      bey = cy + (v2y * m2) / 4;
      if ($urandom_range(0, 1) == 1) begin
        add_pair(bx, by, bex, bey, ax, ay, aex, aey);
      end else begin
        add_pair(ax, ay, aex, aey, bx, by, bex, bey);
      end
    end else if (kind <= 6) begin
      add_pair(rnd(-32768, 32767), rnd(-32768, 32767), rnd(-32768, 32767),
               rnd(-32768, 32767), rnd(-32768, 32767), rnd(-32768, 32767),
               rnd(-32768, 32767), rnd(-32768, 32767));
    end else if (kind <= 8) begin
      // Small coordinates hit parallels, touches and end crossings often.
      add_pair(rnd(-64, 63), rnd(-64, 63), rnd(-64, 63), rnd(-64, 63),
               rnd(-64, 63), rnd(-64, 63), rnd(-64, 63), rnd(-64, 63));
    end else begin
      ax  = rnd(-8000, 8000);
      ay  = rnd(-8000, 8000);
      hx  = rnd(-4000, 4000);
      hy  = rnd(-4000, 4000);
      aex = ax + 2 * hx;
      aey = ay + 2 * hy;
      case ($urandom_range(0, 4))
        0: begin
          cx = rnd(-3000, 3000);
          cy = rnd(-3000, 3000);
          add_pair(ax, ay, aex, aey, ax + cx, ay + cy, aex + cx, aey + cy);
        end
        1: add_pair(ax, ay, aex, aey, ax + hx, ay + hy, aex + hx, aey + hy);
        2: add_pair(ax, ay, aex, aey, aex, aey, rnd(-8000, 8000), rnd(-8000, 8000));
        3: begin
          cx = rnd(-8000, 8000);
          cy = rnd(-8000, 8000);
          add_pair(ax, ay, aex, aey, cx, cy, cx, cy);
        end
        default: add_pair(ax, ay, aex, aey, ax + hx, ay + hy,
                          rnd(-8000, 8000), rnd(-8000, 8000));
      endcase
    end
  endtask

  task automatic add_directed_pairs();
    add_pair(0, 0, 0, 0, 0, 0, 0, 0);
    add_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    add_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    add_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    add_pair(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767);
    add_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767);
    add_pair(0, -256, 0, 256, -256, 0, 256, 0);
    add_pair(0, 0, 256, 256, 0, 256, 256, 512);
    add_pair(0, 0, 512, 0, 256, 0, 768, 0);
    add_pair(0, 0, 512, 0, 256, 0, 256, 0);
    add_pair(0, 0, 256, 0, 256, -256, 256, 256);
    add_pair(0, 0, 512, 0, 256, 0, 256, 256);
    add_pair(0, 0, 256, 256, 0, 0, 256, -256);
    add_pair(0, 0, -3, -7, -3, 0, 0, -7);
    add_pair(-3, -7, 0, 0, -3, 0, 0, -7);
    add_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767);
    add_pair(1, 1, 10, 4, 2, 8, 9, -3);
    add_pair(0, 0, 256, 0, 300, -10, 300, 10);
    add_pair(-100, 50, 200, -75, -100, 50, 200, -75);
    add_pair(21845, -21846, -21846, 21845, -21846, -21846, 21845, 21845);
    add_pair(-32768, 32767, 32767, -32768, 0, -32768, 0, 32767);
    add_pair(-1, -1, 1, 1, -1, 1, 1, -1);
  endtask

  // Sender: bursts of pairs with idle gaps; a pair stays on the bus until taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        crossing_q.push_back(predict_crossing(in_item));
        sent_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 && !long_hold) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pair_q.size() == 0 ||
                     (sent_cnt == DRAIN_AT && crossing_q.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          in_item  <= pair_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // Consumer stall pattern, with one long hold-off that backs up the pipeline.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      long_hold <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && sent_cnt >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_t'($urandom_range(0, 3));
          mode_left  = $urandom_range(16, 128);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          STALL_NONE:   out_stall <= 1'b0;
          STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
          STALL_TOGGLE: out_stall <= !out_stall;
          default:      out_stall <= 1'b0;
        endcase
      end
      long_hold <= (hold_left > 0);
    end
  end

  // Result checker: every transaction must match the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (crossing_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected result: hit=%0b x=%0d y=%0d",
                   out_item.hit, out_item.cross_x, out_item.cross_y);
        end
      end else begin
        want = crossing_q.pop_front();
        if (out_item.hit !== want.hit || out_item.cross_x !== want.cross_x ||
            out_item.cross_y !== want.cross_y) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch: expected hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                     want.hit, want.cross_x, want.cross_y,
                     out_item.hit, out_item.cross_x, out_item.cross_y);
          end
        end
      end
    end
  end

  initial begin
    add_directed_pairs();
    repeat (RANDOM_PAIRS) add_random_pair();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pair_q.size() != 0 || in_valid || crossing_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && crossing_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 12ns);
    $display("FAIL");
    $finish;
  end

endmodule

>>> filelist.f
design/spi_pkg.sv
design/spi_front.sv
design/spi_div.sv
design/spi_obuf.sv
design/segment_pair_intersection_unit.sv
design/spi_checker.sv
dv/tb_top.sv
